/* src/grid_astar_path_search_unit_macros.svh */
// ----------------------------------------------------------------------------
// grid a* search unit assertion macros
// shared assertion wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_MACROS_SVH

// assertion that is switched off while reset is low
`define GAS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds through reset
`define GAS_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/gas_pkg.sv */
// ----------------------------------------------------------------------------
// gas_pkg
// types and constants shared by the grid a* search unit
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [23:0] COST_MAX      = 24'hFFFFFF;
    localparam logic [23:0] COST_STRAIGHT = 24'd1000;
    localparam logic [23:0] COST_DIAG     = 24'd1410;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SAME    = 3'd1,
        ST_OUTSIDE = 3'd2,
        ST_NO_PATH = 3'd3,
        ST_BEYOND  = 3'd4
    } t_status;

    typedef enum logic [25:0] {
        S_CLRMAP  = 26'd1 << 0,
        S_IDLE    = 26'd1 << 1,
        S_DISP    = 26'd1 << 2,
        S_RDWAIT  = 26'd1 << 3,
        S_CLRNODE = 26'd1 << 4,
        S_INIT    = 26'd1 << 5,
        S_POPCHK  = 26'd1 << 6,
        S_POPRD   = 26'd1 << 7,
        S_POPRD2  = 26'd1 << 8,
        S_SDL     = 26'd1 << 9,
        S_SDR     = 26'd1 << 10,
        S_SDC     = 26'd1 << 11,
        S_SDCMP   = 26'd1 << 12,
        S_NODERD  = 26'd1 << 13,
        S_NODEWB  = 26'd1 << 14,
        S_NBADDR  = 26'd1 << 15,
        S_NBBLK   = 26'd1 << 16,
        S_NBNODE  = 26'd1 << 17,
        S_NBF     = 26'd1 << 18,
        S_SU      = 26'd1 << 19,
        S_SUCMP   = 26'd1 << 20,
        S_NBNEXT  = 26'd1 << 21,
        S_PCCHK   = 26'd1 << 22,
        S_PCWT    = 26'd1 << 23,
        S_PSCHK   = 26'd1 << 24,
        S_PSWT    = 26'd1 << 25
    } t_state;

    // controller to datapath
    typedef struct packed {
        t_state op;
        logic   accept;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic clr_done;
        logic search_go;
        logic read_ok;
        logic heap_empty;
        logic sd_stop;
        logic sd_has_r;
        logic sd_stop_cmp;
        logic closed;
        logic at_target;
        logic nb_skip_addr;
        logic nb_skip_blk;
        logic nb_improve;
        logic su_root;
        logic su_stop;
        logic d_last;
        logic pc_at_s;
        logic ps_zero;
    } t_sts;

endpackage

/* src/gas_ram.sv */
// ----------------------------------------------------------------------------
// gas_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gas_ram #(
    parameter int W = 1,
    parameter int D = 2,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/gas_ctrl.sv */
// ----------------------------------------------------------------------------
// gas_ctrl
// sequencer for commands, clearing passes, heap sifts and path walk
// ----------------------------------------------------------------------------
module gas_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gas_pkg::t_sts i_sts,
    output gas_pkg::t_ctl o_ctl,
    output logic          o_busy
);
    import gas_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLRMAP:  if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:    if (i_start) n_state = S_DISP;
            S_DISP: begin
                unique case (i_sts.cmd)
                    CMD_SEARCH: n_state = i_sts.search_go ? S_CLRNODE : S_IDLE;
                    CMD_READ:   n_state = i_sts.read_ok ? S_RDWAIT : S_IDLE;
                    default:    n_state = S_IDLE;
                endcase
            end
            S_RDWAIT:  n_state = S_IDLE;
            S_CLRNODE: if (i_sts.clr_done) n_state = S_INIT;
            S_INIT:    n_state = S_POPCHK;
            S_POPCHK:  n_state = i_sts.heap_empty ? S_IDLE : S_POPRD;
            S_POPRD:   n_state = S_POPRD2;
            S_POPRD2:  n_state = i_sts.heap_empty ? S_NODERD : S_SDL;
            S_SDL:     n_state = i_sts.sd_stop ? S_NODERD : S_SDR;
            S_SDR:     n_state = i_sts.sd_has_r ? S_SDC : S_SDCMP;
            S_SDC:     n_state = S_SDCMP;
            S_SDCMP:   n_state = i_sts.sd_stop_cmp ? S_NODERD : S_SDL;
            S_NODERD:  n_state = S_NODEWB;
            S_NODEWB: begin
                if (i_sts.closed) n_state = S_POPCHK;
                else if (i_sts.at_target) n_state = S_PCCHK;
                else n_state = S_NBADDR;
            end
            S_NBADDR:  n_state = i_sts.nb_skip_addr ? S_NBNEXT : S_NBBLK;
            S_NBBLK:   n_state = i_sts.nb_skip_blk ? S_NBNEXT : S_NBNODE;
            S_NBNODE:  n_state = i_sts.nb_improve ? S_NBF : S_NBNEXT;
            S_NBF:     n_state = S_SU;
            S_SU:      n_state = i_sts.su_root ? S_NBNEXT : S_SUCMP;
            S_SUCMP:   n_state = i_sts.su_stop ? S_NBNEXT : S_SU;
            S_NBNEXT:  n_state = i_sts.d_last ? S_POPCHK : S_NBADDR;
            S_PCCHK:   n_state = i_sts.pc_at_s ? S_PSCHK : S_PCWT;
            S_PCWT:    n_state = S_PCCHK;
            S_PSCHK:   n_state = i_sts.ps_zero ? S_IDLE : S_PSWT;
            S_PSWT:    n_state = S_PSCHK;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLRMAP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl.op     = r_state;
    assign o_ctl.accept = (r_state == S_IDLE) && i_start;
    assign o_busy       = (r_state != S_IDLE);
endmodule

/* src/gas_dp.sv */
// ----------------------------------------------------------------------------
// gas_dp
// grid, node, heap and path stores with the search arithmetic
// ----------------------------------------------------------------------------
module gas_dp #(
    parameter int MAX_WIDTH  = gas_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gas_pkg::DEF_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gas_pkg::t_ctl i_ctl,
    output gas_pkg::t_sts o_sts,
    input  logic [1:0]    i_cmd,
    input  logic [5:0]    i_cell_x,
    input  logic [5:0]    i_cell_y,
    input  logic [5:0]    i_target_x,
    input  logic [5:0]    i_target_y,
    input  logic          i_solid,
    input  logic [11:0]   i_step_index,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_index,
    input  logic [6:0]    i_cfg_data,
    output logic          o_result_valid,
    output logic [2:0]    o_status,
    output logic [11:0]   o_path_length,
    output logic [5:0]    o_step_x,
    output logic [5:0]    o_step_y
);
    import gas_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int IW = XW + YW;
    localparam int CELLS = 1 << IW;
    localparam int KW = 24 + IW;
    localparam int NW = 26;

    localparam logic [9:0] DXV [8] = '{10'h001, 10'h3FF, 10'h000, 10'h000,
                                       10'h001, 10'h3FF, 10'h001, 10'h3FF};
    localparam logic [9:0] DYV [8] = '{10'h000, 10'h000, 10'h001, 10'h3FF,
                                       10'h001, 10'h001, 10'h3FF, 10'h3FF};

    function automatic logic [23:0] f_octile(input logic [7:0] x, input logic [7:0] y,
                                             input logic [5:0] tx, input logic [5:0] ty);
        logic [7:0]  ax;
        logic [7:0]  ay;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [17:0] ph;
        logic [16:0] pl;
        ax = (x > 8'(tx)) ? x - 8'(tx) : 8'(tx) - x;
        ay = (y > 8'(ty)) ? y - 8'(ty) : 8'(ty) - y;
        hi = (ax > ay) ? ax : ay;
        lo = (ax > ay) ? ay : ax;
        ph = 18'(hi) * 18'd1000;
        pl = 17'(lo) * 17'd414;
        return 24'(ph) + 24'(pl);
    endfunction

    function automatic logic [23:0] f_sat(input logic [23:0] a, input logic [23:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? COST_MAX : s[23:0];
    endfunction

    // latched command word
    logic [6:0]    r_gw, r_gh;
    t_cmd          r_cmd;
    logic [5:0]    r_sx, r_sy, r_tx, r_ty;
    logic          r_solid;
    logic [11:0]   r_sidx;
    // search registers
    logic [IW-1:0] r_cnt, r_len, r_cur, r_ni, r_p, r_q, r_pc, r_n, r_i;
    logic [IW:0]   r_count, r_l, r_c;
    logic [23:0]   r_gcur, r_h, r_g;
    logic [2:0]    r_d;
    logic [3:0]    r_orth;
    logic [7:0]    r_nx, r_ny;
    logic          r_wasopen;
    logic [KW-1:0] r_key, r_a;
    // result registers
    logic          r_res_valid;
    t_status       r_res_status;
    logic [11:0]   r_res_len;
    logic [5:0]    r_res_x, r_res_y;

    // ram ports
    logic          map_we, map_wdata, map_rdata;
    logic [IW-1:0] map_waddr, map_raddr;
    logic          node_we;
    logic [IW-1:0] node_waddr, node_raddr;
    logic [NW-1:0] node_wdata, node_rdata;
    logic          cf_we;
    logic [IW-1:0] cf_waddr, cf_raddr, cf_rdata;
    logic          heap_we;
    logic [IW-1:0] heap_waddr, heap_raddr;
    logic [KW-1:0] heap_wdata, heap_rdata;
    logic [IW-1:0] slot_rdata;
    logic          path_we;
    logic [IW-1:0] path_waddr, path_raddr, path_wdata, path_rdata;

    // combinational decode
    logic [8:0]    w9, h9;
    logic [IW-1:0] s_idx, t_idx, wr_idx;
    logic          same, bad, wr_ok;
    logic [7:0]    cx8, cy8;
    logic [9:0]    nx, ny;
    logic [IW-1:0] ni;
    logic          blk_diag;
    logic [23:0]   g_new, f_new;
    logic [IW:0]   l_new;

    assign w9 = (9'(r_gw) > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : 9'(r_gw);
    assign h9 = (9'(r_gh) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(r_gh);
    assign s_idx  = {YW'(r_sy), XW'(r_sx)};
    assign t_idx  = {YW'(r_ty), XW'(r_tx)};
    assign wr_idx = s_idx;
    assign same   = (r_sx == r_tx) && (r_sy == r_ty);
    assign bad    = (w9 == 9'd0) || (h9 == 9'd0) || (9'(r_sx) >= w9) || (9'(r_sy) >= h9)
                 || (9'(r_tx) >= w9) || (9'(r_ty) >= h9);
    assign wr_ok  = (9'(r_sx) < 9'(MAX_WIDTH)) && (9'(r_sy) < 9'(MAX_HEIGHT));

    assign cx8 = 8'(r_cur[XW-1:0]);
    assign cy8 = 8'(r_cur[IW-1:XW]);
    assign nx  = {2'b00, cx8} + DXV[r_d];
    assign ny  = {2'b00, cy8} + DYV[r_d];
    assign ni  = {ny[YW-1:0], nx[XW-1:0]};
    // a diagonal move needs both side cells open
    assign blk_diag = r_d[2] && ((DXV[r_d][9] ? r_orth[1] : r_orth[0])
                              || (DYV[r_d][9] ? r_orth[3] : r_orth[2]));
    assign g_new = f_sat(r_gcur, r_d[2] ? COST_DIAG : COST_STRAIGHT);
    assign f_new = f_sat(r_g, r_h);
    assign l_new = {r_p, 1'b1};

    always_comb begin
        o_sts.cmd          = r_cmd;
        o_sts.clr_done     = &r_cnt;
        o_sts.search_go    = !same && !bad;
        o_sts.read_ok      = (r_sidx < 12'(r_len)) && (r_len != '0 || 1'b1)
                          && ({1'b0, r_sidx} < 13'(r_len));
        o_sts.heap_empty   = (r_count == '0);
        o_sts.sd_stop      = (l_new >= r_count);
        o_sts.sd_has_r     = (r_l < r_count - 1'b1);
        o_sts.sd_stop_cmp  = (r_key <= r_a);
        o_sts.closed       = node_rdata[24];
        o_sts.at_target    = (r_cur == t_idx);
        o_sts.nb_skip_addr = nx[9] || (nx[8:0] >= w9) || ny[9] || (ny[8:0] >= h9);
        o_sts.nb_skip_blk  = map_rdata || blk_diag;
        o_sts.nb_improve   = !node_rdata[24] && (g_new < node_rdata[23:0]);
        o_sts.su_root      = (r_p == '0);
        o_sts.su_stop      = (heap_rdata <= r_key);
        o_sts.d_last       = (r_d == 3'd7);
        o_sts.pc_at_s      = (r_pc == s_idx);
        o_sts.ps_zero      = (r_i == '0);
    end

    // ram port selection
    always_comb begin
        map_we     = 1'b0;
        map_waddr  = r_cnt;
        map_wdata  = 1'b0;
        map_raddr  = ni;
        node_we    = 1'b0;
        node_waddr = r_cnt;
        node_wdata = {2'b00, COST_MAX};
        node_raddr = r_cur;
        cf_we      = 1'b0;
        cf_waddr   = r_ni;
        cf_raddr   = r_pc;
        heap_we    = 1'b0;
        heap_waddr = r_p;
        heap_wdata = r_key;
        heap_raddr = '0;
        path_we    = 1'b0;
        path_waddr = r_i - 1'b1;
        path_wdata = r_pc;
        path_raddr = r_sidx[IW-1:0];
        unique case (i_ctl.op)
            S_CLRMAP: map_we = 1'b1;
            S_DISP: begin
                if (r_cmd == CMD_WRITE && wr_ok) begin
                    map_we    = 1'b1;
                    map_waddr = wr_idx;
                    map_wdata = r_solid;
                end
            end
            S_CLRNODE: node_we = 1'b1;
            S_INIT: begin
                node_we    = 1'b1;
                node_waddr = s_idx;
                node_wdata = {2'b10, 24'd0};
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = {r_h, s_idx};
            end
            S_POPCHK:  heap_raddr = '0;
            S_POPRD:   heap_raddr = r_count[IW-1:0] - 1'b1;
            S_SDL: begin
                heap_we    = o_sts.sd_stop;
                heap_raddr = l_new[IW-1:0];
            end
            S_SDR:     heap_raddr = r_l[IW-1:0] + 1'b1;
            S_SDCMP: begin
                heap_we    = 1'b1;
                heap_wdata = o_sts.sd_stop_cmp ? r_key : r_a;
            end
            S_NODEWB: begin
                node_we    = !node_rdata[24];
                node_waddr = r_cur;
                node_wdata = {2'b01, node_rdata[23:0]};
            end
            S_NBBLK:   node_raddr = r_ni;
            S_NBNODE: begin
                node_we    = o_sts.nb_improve;
                node_waddr = r_ni;
                node_wdata = {2'b10, g_new};
                cf_we      = o_sts.nb_improve;
            end
            S_SU: begin
                heap_we    = o_sts.su_root;
                heap_raddr = IW'((r_p - 1'b1) >> 1);
            end
            S_SUCMP: begin
                heap_we    = 1'b1;
                heap_wdata = o_sts.su_stop ? r_key : heap_rdata;
            end
            S_PSCHK:   path_we = !o_sts.ps_zero;
            default: ;
        endcase
    end

    gas_ram #(.W(1), .D(CELLS)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(map_raddr), .o_rdata(map_rdata)
    );
    gas_ram #(.W(NW), .D(CELLS)) u_node (
        .i_clk(i_clk), .i_we(node_we), .i_waddr(node_waddr), .i_wdata(node_wdata),
        .i_raddr(node_raddr), .o_rdata(node_rdata)
    );
    gas_ram #(.W(IW), .D(CELLS)) u_cf (
        .i_clk(i_clk), .i_we(cf_we), .i_waddr(cf_waddr), .i_wdata(r_cur),
        .i_raddr(cf_raddr), .o_rdata(cf_rdata)
    );
    gas_ram #(.W(KW), .D(CELLS)) u_heap (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_waddr), .i_wdata(heap_wdata),
        .i_raddr(heap_raddr), .o_rdata(heap_rdata)
    );
    // heap position of each open cell, written with every heap write
    gas_ram #(.W(IW), .D(CELLS)) u_slot (
        .i_clk(i_clk), .i_we(heap_we), .i_waddr(heap_wdata[IW-1:0]), .i_wdata(heap_waddr),
        .i_raddr(r_ni), .o_rdata(slot_rdata)
    );
    gas_ram #(.W(IW), .D(CELLS)) u_path (
        .i_clk(i_clk), .i_we(path_we), .i_waddr(path_waddr), .i_wdata(path_wdata),
        .i_raddr(path_raddr), .o_rdata(path_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_h <= f_octile(r_nx, r_ny, r_tx, r_ty);
        if (i_ctl.accept) begin
            r_sx    <= i_cell_x;
            r_sy    <= i_cell_y;
            r_tx    <= i_target_x;
            r_ty    <= i_target_y;
            r_solid <= i_solid;
            r_sidx  <= i_step_index;
        end
        unique case (i_ctl.op)
            S_DISP: begin
                r_nx <= 8'(r_sx);
                r_ny <= 8'(r_sy);
            end
            S_POPRD:  r_cur <= heap_rdata[IW-1:0];
            S_POPRD2: begin
                r_key <= heap_rdata;
                r_p   <= '0;
            end
            S_SDL:    r_l <= l_new;
            S_SDR: begin
                r_a <= heap_rdata;
                r_c <= r_l;
            end
            S_SDC: begin
                if (heap_rdata < r_a) begin
                    r_a <= heap_rdata;
                    r_c <= r_l + 1'b1;
                end
            end
            S_SDCMP:  if (!o_sts.sd_stop_cmp) r_p <= r_c[IW-1:0];
            S_NODEWB: begin
                r_gcur <= node_rdata[23:0];
                r_pc   <= t_idx;
                r_n    <= '0;
            end
            S_NBADDR: begin
                r_nx <= nx[7:0];
                r_ny <= ny[7:0];
                r_ni <= ni;
            end
            S_NBNODE: begin
                r_g       <= g_new;
                r_wasopen <= node_rdata[25];
            end
            S_NBF: begin
                r_key <= {f_new, r_ni};
                r_p   <= r_wasopen ? slot_rdata : r_count[IW-1:0];
            end
            S_SU:     r_q <= IW'((r_p - 1'b1) >> 1);
            S_SUCMP:  if (!o_sts.su_stop) r_p <= r_q;
            S_PCCHK: begin
                if (o_sts.pc_at_s) begin
                    r_i  <= r_n;
                    r_pc <= t_idx;
                end
            end
            S_PCWT: begin
                r_pc <= cf_rdata;
                r_n  <= r_n + 1'b1;
            end
            S_PSWT: begin
                r_pc <= cf_rdata;
                r_i  <= r_i - 1'b1;
            end
            default: ;
        endcase
        // result payload
        r_res_x <= '0;
        r_res_y <= '0;
        unique case (i_ctl.op)
            S_DISP: begin
                r_res_status <= ST_OK;
                r_res_len    <= 12'(r_len);
                if (r_cmd == CMD_WRITE && !wr_ok) r_res_status <= ST_OUTSIDE;
                if (r_cmd == CMD_READ && !o_sts.read_ok) r_res_status <= ST_BEYOND;
                if (r_cmd == CMD_SEARCH) begin
                    r_res_len    <= '0;
                    r_res_status <= same ? ST_SAME : ST_OUTSIDE;
                end
            end
            S_RDWAIT: begin
                r_res_status <= ST_OK;
                r_res_len    <= 12'(r_len);
                r_res_x      <= 6'(path_rdata[XW-1:0]);
                r_res_y      <= 6'(path_rdata[IW-1:XW]);
            end
            S_POPCHK: begin
                r_res_status <= ST_NO_PATH;
                r_res_len    <= '0;
            end
            S_PSCHK: begin
                r_res_status <= ST_OK;
                r_res_len    <= 12'(r_n);
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw        <= 7'd64;
            r_gh        <= 7'd64;
            r_cmd       <= CMD_NONE;
            r_cnt       <= '0;
            r_len       <= '0;
            r_count     <= '0;
            r_d         <= '0;
            r_orth      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WIDTH) r_gw <= i_cfg_data;
                if (i_cfg_index == CFG_HEIGHT) r_gh <= i_cfg_data;
            end
            if (i_ctl.accept) r_cmd <= t_cmd'(i_cmd);
            unique case (i_ctl.op)
                S_CLRMAP:  r_cnt <= r_cnt + 1'b1;
                S_CLRNODE: r_cnt <= r_cnt + 1'b1;
                S_DISP: begin
                    if (r_cmd == CMD_SEARCH) begin
                        r_len       <= '0;
                        r_res_valid <= !o_sts.search_go;
                    end else if (r_cmd == CMD_READ) begin
                        r_res_valid <= !o_sts.read_ok;
                    end else begin
                        r_res_valid <= 1'b1;
                    end
                end
                S_RDWAIT:  r_res_valid <= 1'b1;
                S_INIT:    r_count <= {{IW{1'b0}}, 1'b1};
                S_POPCHK:  r_res_valid <= o_sts.heap_empty;
                S_POPRD:   r_count <= r_count - 1'b1;
                S_NODEWB:  r_d <= '0;
                S_NBBLK:   if (!r_d[2]) r_orth[r_d[1:0]] <= map_rdata;
                S_NBF:     if (!r_wasopen) r_count <= r_count + 1'b1;
                S_NBNEXT:  r_d <= r_d + 1'b1;
                S_PSCHK: begin
                    if (o_sts.ps_zero) begin
                        r_len       <= r_n;
                        r_res_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_status       = r_res_status;
    assign o_path_length  = r_res_len;
    assign o_step_x       = r_res_x;
    assign o_step_y       = r_res_y;
endmodule

/* src/grid_astar_path_search_unit.sv */
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit
// a* path search with 8-way moves on a stored occupancy grid
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low, and every command
// gives exactly one result word, shown for a single cycle with
// o_result_valid; the receiver cannot stall, so capture it then. A cell
// write or an idle command is answered from the dispatch state, a path
// read from the read wait state after it. After reset the grid is cleared
// one cell a cycle (all 2^(XW+YW) cells, 4096 for a 64x64 grid) with
// busy high. A search first resets the per-cell cost store the same way,
// then runs a sift-down for each popped cell and a sift-up for each
// improved neighbor, at a pace set by the heap ram and its one read port.
// The found path is traced back from the target through the came-from store.
// Configuration writes are always ready and should be made while idle.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit #(
    parameter int MAX_WIDTH  = gas_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gas_pkg::DEF_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command word
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    input  logic [5:0]  i_target_x,
    input  logic [5:0]  i_target_y,
    input  logic        i_solid,
    input  logic [11:0] i_step_index,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    // result word
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic [11:0] o_path_length,
    output logic [5:0]  o_step_x,
    output logic [5:0]  o_step_y
);
    import gas_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencer: one state per ram access step
    gas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // stores, heap, cost arithmetic and result registers
    gas_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_cmd          (i_cmd),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_solid        (i_solid),
        .i_step_index   (i_step_index),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_path_length  (o_path_length),
        .o_step_x       (o_step_x),
        .o_step_y       (o_step_y)
    );

    // register writes never wait
    assign o_cfg_ready = 1'b1;
endmodule

/* src/gas_checker.sv */
// ----------------------------------------------------------------------------
// gas_checker
// port level checks on the grid a* search unit
// ----------------------------------------------------------------------------
`include "grid_astar_path_search_unit_macros.svh"

module gas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_result_valid,
    input logic [2:0]  o_status,
    input logic [11:0] o_path_length,
    input logic [5:0]  o_step_x,
    input logic [5:0]  o_step_y
);
    import gas_pkg::*;

    `GAS_ASSERT_RST(a_accept_busy, i_clk, i_rst_n, start && !busy |=> busy, "no busy after accept")
    `GAS_ASSERT_RST(a_result_idle, i_clk, i_rst_n, o_result_valid |-> !busy, "result while busy")
    `GAS_ASSERT_RST(a_fail_len, i_clk, i_rst_n, o_result_valid && (o_status == ST_SAME || o_status == ST_OUTSIDE || o_status == ST_NO_PATH) |-> o_path_length == 12'd0, "failed search kept path")
    `GAS_ASSERT_RST(a_fail_step, i_clk, i_rst_n, o_result_valid && o_status != ST_OK |-> o_step_x == 6'd0 && o_step_y == 6'd0, "step set on failure")
    `GAS_ASSERT(a_single, i_clk, o_result_valid |=> !o_result_valid, "result held two cycles")
endmodule

bind grid_astar_path_search_unit gas_checker u_gas_checker (.*);

/* test/grid_astar_path_search_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit_test
// drives cell writes, searches and path reads into the a* unit, predicts
// every result word with an in-bench a* search and compares field by field
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit_test;
    import gas_pkg::*;

    localparam int CELLS     = 4096;
    localparam int LIMIT     = 4000000;
    localparam int MAX_PRINT = 10;
    localparam int STEP_X[8] = '{1, -1, 0, 0, 1, -1, 1, -1};
    localparam int STEP_Y[8] = '{0, 0, 1, -1, 1, 1, -1, -1};

    typedef struct {
        t_cmd        cmd;
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [5:0]  tx;
        logic [5:0]  ty;
        logic        solid;
        logic [11:0] sidx;
        bit          drain;   // hold off until every result is back
    } t_job;

    typedef struct {
        t_status     status;
        logic [11:0] len;
        logic [5:0]  x;
        logic [5:0]  y;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [5:0]  i_cell_x = '0;
    logic [5:0]  i_cell_y = '0;
    logic [5:0]  i_target_x = '0;
    logic [5:0]  i_target_y = '0;
    logic        i_solid = 1'b0;
    logic [11:0] i_step_index = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [6:0]  i_cfg_data = '0;
    logic        o_result_valid;
    logic [2:0]  o_status;
    logic [11:0] o_path_length;
    logic [5:0]  o_step_x;
    logic [5:0]  o_step_y;

    grid_astar_path_search_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_target_x     (i_target_x),
        .i_target_y     (i_target_y),
        .i_solid        (i_solid),
        .i_step_index   (i_step_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_path_length  (o_path_length),
        .o_step_x       (o_step_x),
        .o_step_y       (o_step_y)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // search model state
    // ------------------------------------------------------------------
    bit          wall[CELLS];
    int unsigned g_cost[CELLS];
    int unsigned f_cost[CELLS];
    int unsigned parent[CELLS];
    bit          done_cell[CELLS];
    bit          listed[CELLS];
    int unsigned frontier[$];
    logic [11:0] route[CELLS];
    int unsigned route_len;
    logic [6:0]  cols_reg = 7'd64;
    logic [6:0]  rows_reg = 7'd64;

    t_job    pending[$];
    t_answer results_due[$];
    int      pause_left = 0;
    bit      taken = 1'b0;
    int      errors = 0;
    int      cycles = 0;

    function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > 32'hFFFFFF) ? 32'hFFFFFF : s;
    endfunction

    function automatic int unsigned octile(int x, int y, int tx, int ty);
        int ax, ay;
        ax = (x > tx) ? x - tx : tx - x;
        ay = (y > ty) ? y - ty : ty - y;
        return (ax > ay) ? ax * 1000 + ay * 414 : ay * 1000 + ax * 414;
    endfunction

    // a* with open set kept as a list, min by {f, cell index}
    function automatic t_status find_route(int sx, int sy, int tx, int ty);
        int w, h, s, t, k, best, idx, cx, cy, nx, ny, ni, n, cur;
        int unsigned g;
        w = (cols_reg > 64) ? 64 : cols_reg;
        h = (rows_reg > 64) ? 64 : rows_reg;
        route_len = 0;
        if (sx == tx && sy == ty) return ST_SAME;
        if (w == 0 || h == 0) return ST_OUTSIDE;
        if (sx >= w || sy >= h || tx >= w || ty >= h) return ST_OUTSIDE;
        for (int i = 0; i < CELLS; i++) begin
            g_cost[i] = 32'hFFFFFF;
            done_cell[i] = 0;
            listed[i] = 0;
        end
        frontier.delete();
        s = sy * 64 + sx;
        t = ty * 64 + tx;
        g_cost[s] = 0;
        f_cost[s] = octile(sx, sy, tx, ty);
        listed[s] = 1;
        frontier.push_back(s);
        while (frontier.size() > 0) begin
            best = 0;
            for (k = 1; k < frontier.size(); k++) begin
                if ({f_cost[frontier[k]], frontier[k]} < {f_cost[frontier[best]], frontier[best]})
                    best = k;
            end
            idx = frontier[best];
            frontier.delete(best);
            listed[idx] = 0;
            if (done_cell[idx]) continue;
            done_cell[idx] = 1;
            cx = idx % 64;
            cy = idx / 64;
            if (idx == t) begin
                n = 0;
                cur = t;
                while (cur != s && n < CELLS) begin
                    cur = parent[cur];
                    n++;
                end
                cur = t;
                for (int i = n; i > 0; i--) begin
                    route[i - 1] = cur[11:0];
                    cur = parent[cur];
                end
                route_len = n;
                return ST_OK;
            end
            for (int d = 0; d < 8; d++) begin
                nx = cx + STEP_X[d];
                ny = cy + STEP_Y[d];
                if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                ni = ny * 64 + nx;
                if (wall[ni]) continue;
                // diagonal refused when a corner cell is solid
                if (d >= 4 && (wall[cy * 64 + nx] || wall[ny * 64 + cx])) continue;
                if (done_cell[ni]) continue;
                g = sat_sum(g_cost[idx], (d < 4) ? 1000 : 1410);
                if (g < g_cost[ni]) begin
                    g_cost[ni] = g;
                    parent[ni] = idx;
                    f_cost[ni] = sat_sum(g, octile(nx, ny, tx, ty));
                    if (!listed[ni]) begin
                        listed[ni] = 1;
                        frontier.push_back(ni);
                    end
                end
            end
        end
        return ST_NO_PATH;
    endfunction

    function automatic t_answer model_command(t_cmd cmd, logic [5:0] cx, logic [5:0] cy,
                                              logic [5:0] tx, logic [5:0] ty, logic solid,
                                              logic [11:0] sidx);
        t_answer a;
        a.status = ST_OK;
        a.x = '0;
        a.y = '0;
        case (cmd)
            CMD_WRITE: begin
                wall[{cy, cx}] = solid;
            end
            CMD_SEARCH: begin
                a.status = find_route(cx, cy, tx, ty);
            end
            CMD_READ: begin
                if (sidx < route_len) begin
                    a.x = route[sidx][5:0];
                    a.y = route[sidx][11:6];
                end else begin
                    a.status = ST_BEYOND;
                end
            end
            default: ;
        endcase
        a.len = route_len[11:0];
        return a;
    endfunction

    // ------------------------------------------------------------------
    // driver: one command word per item, random pause after each
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_job j;
        if (start && !taken) begin
            // word still waiting on busy
        end else if (pause_left > 0) begin
            start <= 1'b0;
            pause_left <= pause_left - 1;
        end else if (pending.size() > 0 && !(pending[0].drain && results_due.size() != 0)) begin
            j = pending.pop_front();
            i_cmd <= j.cmd;
            i_cell_x <= j.cx;
            i_cell_y <= j.cy;
            i_target_x <= j.tx;
            i_target_y <= j.ty;
            i_solid <= j.solid;
            i_step_index <= j.sidx;
            start <= 1'b1;
            pause_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        end else begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: check result words, predict accepted words, track regs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_answer want;
        cycles <= cycles + 1;
        if (o_result_valid) begin
            if (results_due.size() == 0) begin
                if (errors < MAX_PRINT)
                    $display("unexpected result word: status %0d len %0d x %0d y %0d",
                             o_status, o_path_length, o_step_x, o_step_y);
                errors <= errors + 1;
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status || o_path_length !== want.len ||
                    o_step_x !== want.x || o_step_y !== want.y) begin
                    if (errors < MAX_PRINT)
                        $display("result word differs: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.status, want.len, want.x, want.y,
                                 o_status, o_path_length, o_step_x, o_step_y);
                    errors <= errors + 1;
                end
            end
        end
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            results_due.push_back(model_command(t_cmd'(i_cmd), i_cell_x, i_cell_y,
                                                i_target_x, i_target_y, i_solid, i_step_index));
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_WIDTH) cols_reg = i_cfg_data;
            else rows_reg = i_cfg_data;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("grid_astar_path_search_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic add_job(t_cmd cmd, int cx, int cy, int tx, int ty, int solid, int sidx,
                           bit drain = 0);
        t_job j;
        j.cmd = cmd;
        j.cx = cx;
        j.cy = cy;
        j.tx = tx;
        j.ty = ty;
        j.solid = solid;
        j.sidx = sidx;
        j.drain = drain;
        pending.push_back(j);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (pending.size() != 0 || results_due.size() != 0 || start);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int w, h, r;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // full reset-size grid, open everywhere
        add_job(CMD_SEARCH, 5, 5, 5, 5, 0, 0);
        add_job(CMD_SEARCH, 0, 0, 63, 63, 0, 0);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 0);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 62);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 63);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 4095);
        add_job(CMD_NONE, 63, 63, 63, 63, 1, 4095);
        add_job(CMD_SEARCH, 63, 0, 0, 63, 0, 0);
        wait_idle();

        // small grid: corner cutting, solid target, solid start, outside
        write_reg(CFG_WIDTH, 8);
        write_reg(CFG_HEIGHT, 8);
        add_job(CMD_WRITE, 1, 0, 0, 0, 1, 0);
        add_job(CMD_SEARCH, 0, 0, 1, 1, 0, 0);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 0);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 1);
        add_job(CMD_WRITE, 5, 5, 0, 0, 1, 0);
        add_job(CMD_SEARCH, 0, 0, 5, 5, 0, 0, 1);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 0);
        add_job(CMD_WRITE, 7, 7, 0, 0, 1, 0);
        add_job(CMD_SEARCH, 7, 7, 6, 6, 0, 0);
        add_job(CMD_SEARCH, 0, 0, 8, 0, 0, 0);
        add_job(CMD_SEARCH, 0, 8, 1, 1, 0, 0);
        add_job(CMD_WRITE, 5, 5, 0, 0, 0, 0);
        add_job(CMD_SEARCH, 7, 0, 0, 7, 0, 0);
        wait_idle();

        // degenerate sizes
        write_reg(CFG_WIDTH, 0);
        add_job(CMD_SEARCH, 0, 0, 0, 1, 0, 0);
        wait_idle();
        write_reg(CFG_WIDTH, 1);
        write_reg(CFG_HEIGHT, 1);
        add_job(CMD_SEARCH, 0, 0, 0, 1, 0, 0);
        add_job(CMD_SEARCH, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // values above the maximum act as the maximum
        write_reg(CFG_WIDTH, 127);
        write_reg(CFG_HEIGHT, 127);
        add_job(CMD_SEARCH, 63, 63, 10, 0, 0, 0);
        add_job(CMD_READ, 0, 0, 0, 0, 0, 52);
        wait_idle();

        // random phases on small grids, mostly in-bounds work
        for (int p = 0; p < 4; p++) begin
            w = $urandom_range(2, 12);
            h = $urandom_range(2, 12);
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_HEIGHT, h);
            for (int k = 0; k < 26; k++) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    add_job(CMD_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1), 0, 0,
                            ($urandom_range(0, 3) == 0), 0);
                else if (r < 65)
                    add_job(CMD_SEARCH, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                            $urandom_range(0, w - 1), $urandom_range(0, h - 1), 0, 0,
                            (k == 13));
                else if (r < 85)
                    add_job(CMD_READ, 0, 0, 0, 0, 0, $urandom_range(0, 20));
                else
                    add_job(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 63),
                            $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 1), $urandom_range(0, 4095));
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("grid_astar_path_search_unit: match");
        else
            $display("grid_astar_path_search_unit: mismatch");
        $finish;
    end

endmodule
